[sv/scfg_pkg.sv]
// Shared types, constants and a helper function for the sinc FIR coefficient generator.
package scfg_pkg;

	localparam int MAX_TAPS_DEF        = 63;
	localparam int COEFF_FRAC_BITS_DEF = 30;
	localparam int CORDIC_STEPS        = 30;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] INV_PI_Q32      = 32'd1367130551;

	// Arctangent of 2^-k in units of 2^-32 of a full turn.
	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_LEN     = 2'd1,
		ST_ZERO_ENERGY = 2'd2
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic [23:0] cutoff_freq;
		logic [23:0] sample_rate;
		logic [5:0]  num_taps;
	} req_t;

	typedef struct packed {
		logic signed [31:0] coeff_value;
		logic [5:0]         tap_index;
		logic               last_tap;
		status_t            status;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ERR, S_TAP, S_CDIV, S_RDIV, S_TDIV, S_CORD, S_MUL,
		S_SDIV, S_ACC, S_SQ, S_CHK, S_SQRT, S_RD, S_RDW, S_ODIV
	} state_t;

	// Applies a sign to a magnitude and saturates to the signed 32-bit range.
	function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] q);
		logic [31:0] r;
		if (neg) begin
			if (q > 64'h0000_0000_8000_0000) r = 32'h8000_0000;
			else r = ~q[31:0] + 32'd1;
		end else begin
			if (q > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
			else r = q[31:0];
		end
		return r;
	endfunction

endpackage

[sv/scfg_divider.sv]
// Shared restoring divider for 64-bit unsigned operands, one quotient bit per cycle.
module scfg_divider import scfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, quot_q, den_q;
	logic [64:0] trial;
	logic        fits;

	// One restoring step: shift in the next numerator bit and try a subtraction.
	always_comb begin
		trial = {rem_q, quot_q[63]};
		fits  = trial >= {1'b0, den_q};
	end

	// Control: iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			quot_q <= {quot_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

[sv/scfg_cordic.sv]
// Iterative rotation-mode CORDIC sine, one micro-rotation per cycle.
module scfg_cordic import scfg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        turn,
	output logic               done,
	output logic signed [33:0] sin_val
);

	logic               busy_q, done_q, flip_q;
	logic [4:0]         cnt_q;
	logic signed [33:0] x_q, y_q, z_q, xs, ys, ang;
	logic               flip;
	logic [31:0]        folded;

	// Fold the angle into the quarter turn either side of zero.
	always_comb begin
		flip   = (turn >= 32'h4000_0000) && (turn < 32'hC000_0000);
		folded = flip ? turn - 32'h8000_0000 : turn;
		xs     = x_q >>> cnt_q;
		ys     = y_q >>> cnt_q;
		ang    = $signed({2'b00, ATAN_TURNS[cnt_q]});
	end

	// Control: step count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: rotate towards zero residual angle.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed({2'b00, CORDIC_GAIN_Q30});
			y_q    <= '0;
			z_q    <= $signed({{2{folded[31]}}, folded});
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign done    = done_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

[sv/scfg_isqrt.sv]
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
module scfg_isqrt import scfg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q, res_q, bit_q, trial;

	assign trial = res_q + bit_q;

	// Control: 32 steps and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: digit-by-digit root; leading steps with a too-large bit leave zero.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

[sv/scfg_tapmem.sv]
// Raw tap store: one write port and one registered read port.
module scfg_tapmem import scfg_pkg::*; #(
	parameter int DEPTH = MAX_TAPS_DEF,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/sinc_fir_coefficient_generator_unit.sv]
// Top level: request sequencer for the windowed-sinc FIR coefficient generator.
//
// Usage: drive req and raise start; the transaction is taken at a clock edge where
// start is high and busy is low. busy stays high until the last result of the run
// has been registered. Each result is registered on result and marked by result_strobe
// for exactly one cycle, taps in order with last_tap on the final one. The receiver
// cannot stall the block; it must take every strobed result.
// A bad length or zero sample rate yields one error result, registered from S_ERR.
// Otherwise each side tap takes three passes through the shared 64-step divider
// and one CORDIC run, and the centre tap one division; then the energy check and
// square root run, and each emitted tap takes a memory read plus one division.
// The shared divider sets the pace.
// Reset (arst_n low) returns the sequencer to idle and drops the strobe; the tap
// store is not cleared, as every entry is written before it is read.
module sinc_fir_coefficient_generator_unit import scfg_pkg::*; #(
	parameter int MAX_TAPS        = MAX_TAPS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  req_t    req,
	output result_t result,
	output logic    result_strobe
);

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	state_t      state_q, state_d;
	req_t        req_q;
	status_t     err_q;
	logic [5:0]  k_q;
	logic [31:0] v_q, norm_q;
	logic [63:0] sq_q, energy_q, prod_q;
	logic        sneg_q, tneg_q;
	result_t     result_q;
	logic        strobe_q;

	logic [4:0]  half, m;
	logic [28:0] fcm;
	logic        last_k, bad_len;

	logic        div_start, div_done;
	logic [63:0] div_num, div_den, div_quot, div_rem;
	logic        cor_start, cor_done;
	logic signed [33:0] sin_val;
	logic [32:0] sin_mag;
	logic        sq_start, sq_done;
	logic [31:0] root;
	logic        mem_we, mem_re;
	logic [31:0] rdata, tmag;
	logic [31:0] centre;
	logic [63:0] hp_diff;

	// Distance from the centre, phase product and run bookkeeping.
	always_comb begin
		half    = req_q.num_taps[5:1];
		m       = (k_q > {1'b0, half}) ? 5'(k_q - {1'b0, half}) : 5'({1'b0, half} - k_q);
		fcm     = {5'd0, req_q.cutoff_freq} * {24'd0, m};
		last_k  = (k_q == 6'(req_q.num_taps - 6'd1));
		bad_len = !req.num_taps[0] || ({1'b0, req.num_taps} > 7'(MAX_TAPS));
		sin_mag = sin_val[33] ? 33'(-sin_val) : sin_val[32:0];
		tmag    = rdata[31] ? (~rdata + 32'd1) : rdata;
		hp_diff = div_quot - 64'h4000_0000;
		if (!req_q.req_type) centre = sat_mag(1'b0, div_quot);
		else if (div_quot <= 64'h4000_0000) centre = 32'(64'h4000_0000 - div_quot);
		else centre = sat_mag(1'b1, hp_diff);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) begin
				if (bad_len || req.sample_rate == 24'd0) state_d = S_ERR;
				else state_d = S_TAP;
			end
			S_ERR:  state_d = S_IDLE;
			S_TAP:  state_d = (m == 5'd0) ? S_CDIV : S_RDIV;
			S_CDIV: if (div_done) state_d = S_ACC;
			S_RDIV: if (div_done) state_d = S_TDIV;
			S_TDIV: if (div_done) state_d = S_CORD;
			S_CORD: if (cor_done) state_d = S_MUL;
			S_MUL:  state_d = S_SDIV;
			S_SDIV: if (div_done) state_d = S_ACC;
			S_ACC:  state_d = S_SQ;
			S_SQ:   state_d = last_k ? S_CHK : S_TAP;
			S_CHK:  state_d = (energy_q == 64'd0) ? S_ERR : S_SQRT;
			S_SQRT: if (sq_done) state_d = S_RD;
			S_RD:   state_d = S_RDW;
			S_RDW:  state_d = S_ODIV;
			S_ODIV: if (div_done) state_d = last_k ? S_IDLE : S_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// Unit control and operand selection.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = {40'd0, req_q.sample_rate};
		cor_start = 1'b0;
		sq_start  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			S_TAP: begin
				div_start = 1'b1;
				if (m == 5'd0)
					div_num = ({40'd0, req_q.cutoff_freq} << 31)
						+ {41'd0, req_q.sample_rate[23:1]};
				else
					div_num = {35'd0, fcm};
			end
			S_RDIV: begin
				div_start = div_done;
				div_num   = {8'd0, div_rem[23:0], 32'd0};
			end
			S_TDIV: cor_start = div_done;
			S_MUL: begin
				div_start = 1'b1;
				div_num   = prod_q + ({59'd0, m} << 31);
				div_den   = {27'd0, m, 32'd0};
			end
			S_ACC:  mem_we = 1'b1;
			S_CHK:  sq_start = (energy_q != 64'd0);
			S_RD:   mem_re = 1'b1;
			S_RDW: begin
				div_start = 1'b1;
				div_num   = ({32'd0, tmag} << COEFF_FRAC_BITS) + ({32'd0, norm_q} << 2);
				div_den   = {32'd0, norm_q} << 3;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
			k_q      <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == S_ERR) || (state_q == S_ODIV && div_done);
			if (state_q == S_IDLE || (state_q == S_SQRT && sq_done)) k_q <= '0;
			else if ((state_q == S_SQ && !last_k) || (state_q == S_ODIV && div_done))
				k_q <= k_q + 6'd1;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				req_q    <= req;
				energy_q <= '0;
				err_q    <= bad_len ? ST_BAD_LEN : ST_ZERO_ENERGY;
			end
			S_ERR: begin
				result_q.coeff_value <= '0;
				result_q.tap_index   <= '0;
				result_q.last_tap    <= 1'b1;
				result_q.status      <= err_q;
			end
			S_CDIV: if (div_done) v_q <= centre;
			S_CORD: if (cor_done) begin
				prod_q <= {31'd0, sin_mag} * {33'd0, INV_PI_Q32[30:0]};
				sneg_q <= sin_val[33];
			end
			S_SDIV: if (div_done) v_q <= sat_mag(sneg_q ^ req_q.req_type, div_quot);
			S_ACC:  sq_q <= 64'($signed(v_q) * $signed(v_q));
			S_SQ:   energy_q <= energy_q + (sq_q >> 6);
			S_CHK:  err_q <= ST_ZERO_ENERGY;
			S_SQRT: if (sq_done) norm_q <= root;
			S_RDW:  tneg_q <= rdata[31];
			S_ODIV: if (div_done) begin
				result_q.coeff_value <= sat_mag(tneg_q, div_quot);
				result_q.tap_index   <= k_q;
				result_q.last_tap    <= last_k;
				result_q.status      <= ST_OK;
			end
			default: ;
		endcase
	end

	scfg_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot), .rem(div_rem)
	);

	scfg_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .turn(div_quot[31:0]),
		.done(cor_done), .sin_val(sin_val)
	);

	scfg_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(energy_q),
		.done(sq_done), .root(root)
	);

	scfg_tapmem #(.DEPTH(MAX_TAPS), .AW(AW)) u_mem (
		.clk(clk), .we(mem_we), .waddr(k_q[AW-1:0]), .wdata(v_q),
		.re(mem_re), .raddr(k_q[AW-1:0]), .rdata(rdata)
	);

	assign busy          = (state_q != S_IDLE);
	assign result        = result_q;
	assign result_strobe = strobe_q;

	// An error result always closes its run.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.status != ST_OK |-> result.last_tap)
		else $error("error result without last_tap");

	// More taps follow a non-final result, so the block stays busy.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last_tap |-> busy)
		else $error("idle while a run is unfinished");

	// A new transaction never starts with a result already on the port.
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !result_strobe)
		else $error("result strobe at the start of a run");

endmodule
